FILE: rtl/calendar_date_arithmetic_assert.svh
// Assertion macros for the calendar date arithmetic block.
// Used by the RTL module that checks its own sequencing.
`ifndef CALENDAR_DATE_ARITHMETIC_ASSERT_SVH
`define CALENDAR_DATE_ARITHMETIC_ASSERT_SVH

// Clocked implication check, disabled while reset is asserted.
`define CDA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check, disabled while reset is asserted.
`define CDA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cda_pkg.sv
// Package for the calendar date arithmetic block: operation codes, relation
// codes, the month length table and the leap-year test. No dependencies.
`default_nettype none
package cda_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MON_W  = 4;
  localparam int unsigned DAY_W  = 5;
  localparam int unsigned DIFF_W = 23;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_ADD_ST  = 3'd1,
    OP_SUB_ST  = 3'd2,
    OP_ADD_RET = 3'd3,
    OP_SUB_RET = 3'd4,
    OP_CMP     = 3'd5
  } op_t;

  localparam logic [1:0] REL_LESS    = 2'd0;
  localparam logic [1:0] REL_EQUAL   = 2'd1;
  localparam logic [1:0] REL_GREATER = 2'd2;

  localparam logic signed [DIFF_W-1:0] DIFF_MAX = 23'sd4194303;
  localparam logic signed [DIFF_W-1:0] DIFF_MIN = -23'sd4194304;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
  } date_t;

  // The quotient by 25 comes from a reciprocal multiplication that is exact
  // for every 12-bit value.
  function automatic logic mult_of_25(input logic [11:0] x);
    logic [24:0] prod;
    logic [7:0]  q;
    prod = 25'(x) * 25'd5243;
    q    = prod[24:17];
    return (x == 12'(q) * 12'd25);
  endfunction

  // A multiple of 100 is a multiple of 4 whose quarter is a multiple of 25,
  // and a multiple of 400 is a multiple of 16 whose sixteenth is one.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic m4, m100, m400;
    m4   = (y[1:0] == 2'b00);
    m100 = m4 && mult_of_25(y[YEAR_W-1:2]);
    m400 = (y[3:0] == 4'b0000) && mult_of_25({2'b00, y[YEAR_W-1:4]});
    return (m4 && !m100) || m400;
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0] y,
                                                  input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:    n = is_leap(y) ? 5'd29 : 5'd28;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/calendar_date_arithmetic.sv
// Calendar date arithmetic unit: one stored Gregorian date; load, add, subtract, compare.
// Load and items rejected at the check go from S_CHECK straight to S_OUT; add and subtract
// go through S_WAIT while the walker moves the date one month at a time, and compare steps
// month by month between the dates in S_CMPW. One item at a time: in_stall stays high from
// acceptance until the result is taken, and the next item is taken back in S_IDLE.
// Synchronous active-low reset sets the stored date to 1900-01-01 and empties the output.
`default_nettype none
module calendar_date_arithmetic
  import cda_pkg::*;
#(
  parameter int unsigned YEAR_MIN      = 1900,
  parameter int unsigned YEAR_MAX      = 9999,
  parameter int unsigned MAX_DAY_COUNT = 65535
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        in_operation,
  input  wire logic [15:0]       in_day_count,
  input  wire logic [YEAR_W-1:0] in_other_year,
  input  wire logic [MON_W-1:0]  in_other_month,
  input  wire logic [DAY_W-1:0]  in_other_day,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [YEAR_W-1:0]      out_year,
  output logic [MON_W-1:0]       out_month,
  output logic [DAY_W-1:0]       out_day,
  output logic [1:0]             out_relation,
  output logic signed [DIFF_W-1:0] out_difference,
  output logic                   out_error
);

  `include "calendar_date_arithmetic_assert.svh"

  localparam int unsigned CNT_W = 23;
  localparam logic [CNT_W-1:0] CNT_CLAMP = CNT_W'(MAX_DAY_COUNT);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_WAIT, S_CMPW, S_OUT} state_t;

  state_t            state_r;
  logic [2:0]        op_r;
  logic [CNT_W-1:0]  cnt_r;
  date_t             oth_r, st_r, res_r;
  logic              err_r;
  logic [1:0]        rel_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic [CNT_W-1:0]  acc_r;
  logic              later_r;
  date_t             lo_r, hi_r;

  logic              w_start, w_fwd, w_done;
  logic [CNT_W-1:0]  w_count;
  date_t             w_from, w_to;
  logic              oth_ok, is_add;
  logic [DAY_W-1:0]  oth_len;
  logic [DAY_W-1:0]  lo_len;
  logic              same_month;
  logic [CNT_W-1:0]  step;
  logic [CNT_W-1:0]  acc_nxt;

  assign oth_len = month_days(oth_r.year, oth_r.month);
  assign oth_ok  = (oth_r.year >= YEAR_W'(YEAR_MIN)) && (oth_r.year <= YEAR_W'(YEAR_MAX))
                && (oth_r.month >= 4'd1) && (oth_r.month <= 4'd12)
                && (oth_r.day >= 5'd1) && (oth_r.day <= oth_len);
  assign is_add  = (op_r == OP_ADD_ST) || (op_r == OP_ADD_RET);

  // Compare walk: lo_r steps month by month up to hi_r, accumulating days.
  assign lo_len     = month_days(lo_r.year, lo_r.month);
  assign same_month = (lo_r.year == hi_r.year) && (lo_r.month == hi_r.month);
  assign step       = same_month ? CNT_W'(hi_r.day - lo_r.day)
                                 : CNT_W'(lo_len - lo_r.day + 5'd1);
  assign acc_nxt    = acc_r + step;

  assign w_start = (state_r == S_CHECK) && (op_r >= OP_ADD_ST) && (op_r <= OP_SUB_RET);
  assign w_fwd   = is_add;
  assign w_count = cnt_r;
  assign w_from  = st_r;

  cda_walker #(.CNT_W(CNT_W)) u_walk (
    .clk(clk), .rst_n(rst_n), .start(w_start), .fwd(w_fwd), .count(w_count),
    .from_date(w_from), .done(w_done), .to_date(w_to)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= '{year: YEAR_W'(1900), month: 4'd1, day: 5'd1};
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= in_operation;
            cnt_r   <= (CNT_W'(in_day_count) > CNT_CLAMP) ? CNT_CLAMP
                                                           : CNT_W'(in_day_count);
            oth_r   <= '{year: in_other_year, month: in_other_month, day: in_other_day};
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_r  <= st_r;
          rel_r  <= REL_LESS;
          diff_r <= '0;
          err_r  <= 1'b0;
          case (op_r)
            OP_LOAD: begin
              if (oth_ok) begin
                st_r  <= oth_r;
                res_r <= oth_r;
              end else begin
                err_r <= 1'b1;
              end
              state_r <= S_OUT;
            end
            OP_ADD_ST, OP_SUB_ST, OP_ADD_RET, OP_SUB_RET: state_r <= S_WAIT;
            OP_CMP: begin
              if (oth_ok) begin
                acc_r   <= '0;
                later_r <= ({st_r.year, st_r.month, st_r.day} >
                            {oth_r.year, oth_r.month, oth_r.day});
                if ({st_r.year, st_r.month, st_r.day} >
                    {oth_r.year, oth_r.month, oth_r.day}) begin
                  lo_r <= oth_r;
                  hi_r <= st_r;
                end else begin
                  lo_r <= st_r;
                  hi_r <= oth_r;
                end
                state_r <= S_CMPW;
              end else begin
                err_r   <= 1'b1;
                state_r <= S_OUT;
              end
            end
            default: begin
              err_r   <= 1'b1;
              state_r <= S_OUT;
            end
          endcase
        end
        S_WAIT: begin
          if (w_done) begin
            if (w_to.year < YEAR_W'(YEAR_MIN) || w_to.year > YEAR_W'(YEAR_MAX)
                || (!is_add && w_to.year > st_r.year)
                || (is_add && w_to.year < st_r.year)) begin
              err_r <= 1'b1;
            end else begin
              res_r <= w_to;
              if (op_r == OP_ADD_ST || op_r == OP_SUB_ST) st_r <= w_to;
            end
            state_r <= S_OUT;
          end
        end
        S_CMPW: begin
          acc_r <= acc_nxt;
          if (same_month) begin
            if (later_r) begin
              diff_r <= acc_nxt[DIFF_W-1] ? DIFF_MAX : DIFF_W'(acc_nxt);
            end else begin
              diff_r <= acc_nxt[DIFF_W-1] ? DIFF_MIN : -DIFF_W'(acc_nxt);
            end
            rel_r   <= (acc_nxt == '0) ? REL_EQUAL
                     : (later_r ? REL_GREATER : REL_LESS);
            state_r <= S_OUT;
          end else begin
            lo_r.day   <= 5'd1;
            lo_r.month <= (lo_r.month == 4'd12) ? 4'd1 : lo_r.month + 4'd1;
            if (lo_r.month == 4'd12) lo_r.year <= lo_r.year + 14'd1;
          end
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = (state_r == S_OUT);
  assign out_year       = res_r.year;
  assign out_month      = res_r.month;
  assign out_day        = res_r.day;
  assign out_relation   = rel_r;
  assign out_difference = diff_r;
  assign out_error      = err_r;

  `CDA_ASSERT_IMP(a_busy_stall, clk, rst_n, out_valid, in_stall, "result shown while ready")
  `CDA_ASSERT_IMP(a_err_rel, clk, rst_n, out_valid && out_error,
                  out_relation == REL_LESS && out_difference == '0, "error with relation")
  `CDA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall,
                  out_valid && $stable(out_year) && $stable(out_error), "result dropped")

endmodule
`default_nettype wire

FILE: rtl/cda_walker.sv
// Day walker for the calendar date arithmetic block: moves a date forward or
// backward by a day count, one month per cycle. Depends on cda_pkg.
`default_nettype none
module cda_walker
  import cda_pkg::*;
#(
  parameter int unsigned CNT_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             fwd,
  input  wire logic [CNT_W-1:0] count,
  input  wire date_t            from_date,
  output logic                  done,
  output date_t                 to_date
);

  typedef enum logic [1:0] {W_IDLE, W_RUN, W_DONE} wstate_t;

  wstate_t          state_r;
  logic [CNT_W-1:0] rem_r;
  logic             fwd_r;
  date_t            cur_r;
  logic [DAY_W-1:0] mlen;
  logic [DAY_W-1:0] plen;
  logic [MON_W-1:0] pmon;
  logic [YEAR_W-1:0] pyear;
  logic [CNT_W-1:0] room;

  assign mlen  = month_days(cur_r.year, cur_r.month);
  assign pmon  = (cur_r.month == 4'd1) ? 4'd12 : cur_r.month - 4'd1;
  assign pyear = (cur_r.month == 4'd1) ? cur_r.year - 14'd1 : cur_r.year;
  assign plen  = month_days(pyear, pmon);
  // Forward: days to the first of next month. Backward: days to the last
  // day of the previous month.
  assign room  = fwd_r ? CNT_W'(mlen - cur_r.day + 5'd1) : CNT_W'(cur_r.day);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= W_IDLE;
    end else begin
      unique case (state_r)
        W_IDLE: begin
          if (start) begin
            rem_r   <= count;
            fwd_r   <= fwd;
            cur_r   <= from_date;
            state_r <= W_RUN;
          end
        end
        W_RUN: begin
          if (rem_r == '0) begin
            state_r <= W_DONE;
          end else if (rem_r < room) begin
            cur_r.day <= fwd_r ? cur_r.day + rem_r[DAY_W-1:0]
                               : cur_r.day - rem_r[DAY_W-1:0];
            rem_r     <= '0;
          end else if (fwd_r) begin
            rem_r       <= rem_r - room;
            cur_r.day   <= 5'd1;
            cur_r.month <= (cur_r.month == 4'd12) ? 4'd1 : cur_r.month + 4'd1;
            if (cur_r.month == 4'd12) cur_r.year <= cur_r.year + 14'd1;
          end else begin
            rem_r       <= rem_r - room;
            cur_r.day   <= plen;
            cur_r.month <= pmon;
            cur_r.year  <= pyear;
          end
        end
        W_DONE: state_r <= W_IDLE;
        default: state_r <= W_IDLE;
      endcase
    end
  end

  assign done    = (state_r == W_DONE);
  assign to_date = cur_r;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the calendar date arithmetic block: a driver
// feeds items from a queue, a monitor checks each result against a date model.
// Depends on cda_pkg and the calendar_date_arithmetic RTL.
`timescale 1ns / 100ps
module testbench;
  import cda_pkg::*;

  localparam int YMIN = 1900;
  localparam int YMAX = 9999;
  localparam int WATCHDOG = 400000;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] cnt;
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
  } item_t;

  typedef struct {
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [1:0]  rel;
    logic [22:0] diff;
    logic        err;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_operation = '0;
  logic [15:0] in_day_count = '0;
  logic [13:0] in_other_year = '0;
  logic [3:0] in_other_month = '0;
  logic [4:0] in_other_day = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [13:0] out_year;
  logic [3:0] out_month;
  logic [4:0] out_day;
  logic [1:0] out_relation;
  logic signed [22:0] out_difference;
  logic out_error;

  item_t pending_items[$];
  result_t expected_results[$];
  int sy = 1900, sm = 1, sd = 1;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0, stall_pct = 0;
  int hold_off = 0;
  bit stimulus_done = 0;

  calendar_date_arithmetic uut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_length(longint y, int m);
    int lens[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) return 0;
    return lens[m] + ((m == 2 && leap_year(y)) ? 1 : 0);
  endfunction

  function automatic bit valid_date(int y, int m, int d);
    return y >= YMIN && y <= YMAX && m >= 1 && m <= 12 && d >= 1 &&
      d <= month_length(y, m);
  endfunction

  function automatic longint first_day_of_year(longint y);
    longint p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic longint day_number(int y, int m, int d);
    longint s;
    s = first_day_of_year(y);
    for (int k = 1; k < m; k++) s += month_length(y, k);
    return s + d - 1;
  endfunction

  function automatic result_t apply_date_op(item_t it);
    result_t r;
    longint s, rem, yy;
    int mm;
    bit add;
    r.y = 14'(sy); r.m = 4'(sm); r.d = 5'(sd); r.rel = REL_LESS; r.diff = '0;
    r.err = 1'b0;
    case (it.op)
      OP_LOAD: begin
        if (valid_date(it.y, it.m, it.d)) begin
          sy = it.y; sm = it.m; sd = it.d;
          r.y = it.y; r.m = it.m; r.d = it.d;
        end else r.err = 1'b1;
      end
      OP_ADD_ST, OP_SUB_ST, OP_ADD_RET, OP_SUB_RET: begin
        add = (it.op == OP_ADD_ST || it.op == OP_ADD_RET);
        s = day_number(sy, sm, sd);
        s = add ? s + it.cnt : s - it.cnt;
        if (s < first_day_of_year(YMIN) || s >= first_day_of_year(YMAX + 1)) begin
          r.err = 1'b1;
        end else begin
          yy = s / 366 + 1;
          while (first_day_of_year(yy + 1) <= s) yy++;
          rem = s - first_day_of_year(yy);
          mm = 1;
          while (rem >= month_length(yy, mm)) begin
            rem -= month_length(yy, mm);
            mm++;
          end
          r.y = 14'(yy); r.m = 4'(mm); r.d = 5'(rem + 1);
          if (it.op == OP_ADD_ST || it.op == OP_SUB_ST) begin
            sy = int'(yy); sm = mm; sd = int'(rem + 1);
          end
        end
      end
      OP_CMP: begin
        if (valid_date(it.y, it.m, it.d)) begin
          s = day_number(sy, sm, sd) - day_number(it.y, it.m, it.d);
          r.rel = s < 0 ? REL_LESS : (s == 0 ? REL_EQUAL : REL_GREATER);
          if (s > 4194303) s = 4194303;
          if (s < -4194304) s = -4194304;
          r.diff = s[22:0];
        end else r.err = 1'b1;
      end
      default: r.err = 1'b1;
    endcase
    return r;
  endfunction

  function automatic item_t make_item(int op, int cnt, int y, int m, int d);
    item_t it;
    it.op = 3'(op); it.cnt = 16'(cnt); it.y = 14'(y); it.m = 4'(m); it.d = 5'(d);
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int r;
    it.op = 3'($urandom_range(0, 99) < 3 ? $urandom_range(6, 7) : $urandom_range(0, 5));
    r = int'($urandom_range(0, 9));
    it.cnt = 16'(r < 6 ? $urandom_range(0, 800)
                       : (r < 8 ? $urandom_range(0, 9000) : $urandom));
    if ($urandom_range(0, 9) < 8) begin
      it.y = 14'($urandom_range(0, 1) ? $urandom_range(1900, 2200)
                                      : $urandom_range(1900, 9999));
      it.m = 4'($urandom_range(1, 12));
      it.d = 5'($urandom_range(1, 9) < 8 ? $urandom_range(1, 28) : $urandom_range(28, 31));
    end else begin
      it.y = 14'($urandom); it.m = 4'($urandom); it.d = 5'($urandom);
    end
    return it;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        item_t it;
        it = pending_items.pop_front();
        expected_results.push_back(apply_date_op(it));
        in_valid <= 1'b1;
        in_operation <= it.op;
        in_day_count <= it.cnt;
        in_other_year <= it.y;
        in_other_month <= it.m;
        in_other_day <= it.d;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(0, 99) < stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item %0d-%0d-%0d",
          out_year, out_month, out_day);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        if (out_year !== e.y || out_month !== e.m || out_day !== e.d ||
            out_relation !== e.rel || out_difference !== e.diff ||
            out_error !== e.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %0d-%0d-%0d rel %0d diff %0d err %0d, got %0d-%0d-%0d rel %0d diff %0d err %0d",
              e.y, e.m, e.d, e.rel, $signed(e.diff), e.err, out_year, out_month,
              out_day, out_relation, out_difference, out_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= WATCHDOG) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_items.size() == 0);
    @(posedge clk);
    while (expected_results.size() > 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    int pcts[4][2] = '{'{0, 0}, '{54, 0}, '{0, 54}, '{12, 12}};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    pending_items.push_back(make_item(OP_ADD_ST, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SUB_RET, 1, 0, 0, 0));
    pending_items.push_back(make_item(OP_LOAD, 0, 2000, 2, 29));
    pending_items.push_back(make_item(OP_LOAD, 0, 1900, 2, 29));
    pending_items.push_back(make_item(OP_LOAD, 0, 2023, 13, 1));
    pending_items.push_back(make_item(OP_LOAD, 0, 2023, 4, 31));
    pending_items.push_back(make_item(OP_LOAD, 0, 2023, 0, 0));
    pending_items.push_back(make_item(OP_LOAD, 0, 16383, 15, 31));
    pending_items.push_back(make_item(OP_LOAD, 0, 1899, 12, 31));
    pending_items.push_back(make_item(OP_ADD_RET, 365, 0, 0, 0));
    pending_items.push_back(make_item(OP_ADD_ST, 65535, 0, 0, 0));
    pending_items.push_back(make_item(OP_SUB_ST, 65535, 0, 0, 0));
    pending_items.push_back(make_item(OP_CMP, 0, 1900, 1, 1));
    pending_items.push_back(make_item(OP_CMP, 0, 2000, 2, 29));
    pending_items.push_back(make_item(OP_CMP, 0, 9999, 12, 31));
    pending_items.push_back(make_item(OP_CMP, 0, 2001, 2, 29));
    pending_items.push_back(make_item(OP_LOAD, 0, 9999, 12, 31));
    pending_items.push_back(make_item(OP_ADD_ST, 1, 0, 0, 0));
    pending_items.push_back(make_item(OP_SUB_RET, 65535, 0, 0, 0));
    pending_items.push_back(make_item(OP_CMP, 0, 1900, 1, 1));
    pending_items.push_back(make_item(6, 0, 0, 0, 0));
    pending_items.push_back(make_item(7, 65535, 16383, 15, 31));
    drain();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pcts[p][0];
      stall_pct = pcts[p][1];
      if (p == 2) hold_off = 300;
      for (int i = 0; i < 62; i++) pending_items.push_back(random_item());
      drain();
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
